FILE: hdl/tmq_pkg.sv
`timescale 1ns / 1ps

package tmq_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FORMAT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] NUM_SAMPLES_RST = 7'd64;
  localparam logic                  CODE_FORMAT_RST = 1'b1;

  // code_format values
  localparam logic FMT_8BIT  = 1'b0;
  localparam logic FMT_16BIT = 1'b1;

  // word widths at the ports
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CODE_W        = 16;
  localparam int unsigned CODE_W_NARROW = 8;

  // divider step counter, counts quotient bits down
  localparam int unsigned STEP_W = 4;

endpackage

FILE: hdl/tmq_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one read port, registered read.
module tmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/trace_minmax_quantizer_top.sv
`timescale 1ns / 1ps

// Min/max linear quantiser for one trace. Samples are written one word per
// cycle (start_i while busy_o is low); the running minimum and maximum are
// tracked as they arrive. The sample that completes the trace (num_samples
// of them, 0 taken as 1, values above MAX_SAMPLES taken as MAX_SAMPLES)
// raises busy_o, and the block then plays back one code word per stored
// sample, in order: code = round half up of (x - min) * maxcode / range,
// maxcode being 65535 or 255 per code_format, with the trace minimum, the
// range and a last-word flag alongside. A zero range gives code 0. Each
// result word is shown for exactly one cycle under result_valid_o; the
// receiver cannot stall, so it must take every strobe. After the last
// sample, S_RANGE forms the range; then each code word passes through
// RAM read, offset, numerator, then the restoring divider at one quotient
// bit per cycle. The strobe of the final word falls in the first cycle
// with busy_o low, so the next trace may start in that cycle. The user
// must write configuration only while the block is idle; the block itself
// does not enforce this.
module trace_minmax_quantizer_top #(
  parameter int unsigned MAX_SAMPLES  = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [tmq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tmq_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // sample words in
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [tmq_pkg::DATA_W-1:0]    sample_value_i,
  // code words out
  output logic                                 result_valid_o,
  output logic [tmq_pkg::CODE_W-1:0]           code_o,
  output logic signed [tmq_pkg::DATA_W-1:0]    trace_minimum_o,
  output logic [tmq_pkg::DATA_W-1:0]           trace_range_o,
  output logic                                 last_code_o
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  // numerator 2*d*maxcode + range stays below 2^SW * 2^17
  localparam int unsigned NW = SW + tmq_pkg::CODE_W + 1;
  localparam int unsigned CW = tmq_pkg::CFG_DATA_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_SAMPLES);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RANGE,
    S_READ,
    S_NUM,
    S_MUL,
    S_DIV
  } state_e;

  state_e                          state_q;

  // configuration registers
  logic [CW-1:0]                   num_samples_q;
  logic                            code_format_q;

  // load side
  logic [AW-1:0]                   load_cnt_q;
  logic signed [SW-1:0]            min_q;
  logic signed [SW-1:0]            max_q;

  // playback side
  logic [AW:0]                     trace_cnt_q;
  logic [AW-1:0]                   idx_q;
  logic [SW-1:0]                   range_q;
  logic [SW-1:0]                   offs_q;
  logic [SW:0]                     rem_q;
  logic [tmq_pkg::CODE_W-1:0]      lo_q;
  logic [tmq_pkg::CODE_W-1:0]      quo_q;
  logic [tmq_pkg::STEP_W-1:0]      step_q;

  // result word
  logic                            valid_q;
  logic [tmq_pkg::CODE_W-1:0]      code_q;
  logic                            last_q;

  logic                            accept;
  logic signed [SW-1:0]            x;
  logic [AW:0]                     count;
  logic [CW-1:0]                   len;
  logic                            trace_done;
  logic [SW-1:0]                   rd_data;
  logic [SW:0]                     max_diff;
  logic [SW:0]                     offs_diff;
  logic [NW-1:0]                   num_shl;
  logic [NW-1:0]                   num;
  logic [SW+1:0]                   trial;
  logic [SW+1:0]                   den;
  logic                            fit;
  logic [SW+1:0]                   trial_sub;
  logic [tmq_pkg::CODE_W-1:0]      quo_next;
  logic                            is_last;

  assign busy_o = (state_q != S_LOAD);
  assign accept = start_i && !busy_o;
  assign x      = sample_value_i[SW-1:0];
  assign count  = {1'b0, load_cnt_q} + (AW+1)'(1);

  // effective trace length
  always_comb begin
    priority if (num_samples_q == '0) begin
      len = CW'(1);
    end else if (num_samples_q > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = num_samples_q;
    end
  end

  assign trace_done = (CW'(count) >= len);

  tmq_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (load_cnt_q),
    .wdata_i (x),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // max - min and x - min are never negative; SW bits hold them
  assign max_diff  = {max_q[SW-1], max_q} - {min_q[SW-1], min_q};
  assign offs_diff = {rd_data[SW-1], rd_data} - {min_q[SW-1], min_q};

  // 2*d*maxcode + range, maxcode = 2^k - 1
  assign num_shl = (code_format_q == tmq_pkg::FMT_16BIT) ?
                   (NW'(offs_q) << (tmq_pkg::CODE_W + 1)) :
                   (NW'(offs_q) << (tmq_pkg::CODE_W_NARROW + 1));
  assign num     = num_shl - (NW'(offs_q) << 1) + NW'(range_q);

  // restoring divider step against 2*range
  assign trial     = {rem_q, lo_q[tmq_pkg::CODE_W-1]};
  assign den       = {1'b0, range_q, 1'b0};
  assign fit       = (trial >= den);
  assign trial_sub = trial - den;
  assign quo_next  = {quo_q[tmq_pkg::CODE_W-2:0], fit};
  assign is_last   = (({1'b0, idx_q} + (AW+1)'(1)) == trace_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      num_samples_q <= tmq_pkg::NUM_SAMPLES_RST;
      code_format_q <= tmq_pkg::CODE_FORMAT_RST;
      load_cnt_q    <= '0;
      min_q         <= '0;
      max_q         <= '0;
      trace_cnt_q   <= '0;
      idx_q         <= '0;
      range_q       <= '0;
      offs_q        <= '0;
      rem_q         <= '0;
      lo_q          <= '0;
      quo_q         <= '0;
      step_q        <= '0;
      valid_q       <= 1'b0;
      code_q        <= '0;
      last_q        <= 1'b0;
    end else begin
      valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tmq_pkg::CFG_NUM_SAMPLES: num_samples_q <= cfg_data_i;
          tmq_pkg::CFG_CODE_FORMAT: code_format_q <= cfg_data_i[0];
        endcase
      end

      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (load_cnt_q == '0) begin
              min_q <= x;
              max_q <= x;
            end else begin
              if (x < min_q) min_q <= x;
              if (x > max_q) max_q <= x;
            end
            if (trace_done) begin
              load_cnt_q  <= '0;
              trace_cnt_q <= count;
              idx_q       <= '0;
              state_q     <= S_RANGE;
            end else begin
              load_cnt_q <= count[AW-1:0];
            end
          end
        end

        S_RANGE: begin
          range_q <= max_diff[SW-1:0];
          state_q <= S_READ;
        end

        // RAM address is idx_q; data lands next cycle
        S_READ: begin
          state_q <= S_NUM;
        end

        S_NUM: begin
          offs_q  <= offs_diff[SW-1:0];
          state_q <= S_MUL;
        end

        S_MUL: begin
          quo_q <= '0;
          if (code_format_q == tmq_pkg::FMT_16BIT) begin
            rem_q  <= num[NW-1:tmq_pkg::CODE_W];
            lo_q   <= num[tmq_pkg::CODE_W-1:0];
            step_q <= tmq_pkg::STEP_W'(tmq_pkg::CODE_W - 1);
          end else begin
            rem_q  <= num[SW+tmq_pkg::CODE_W_NARROW:tmq_pkg::CODE_W_NARROW];
            lo_q   <= {num[tmq_pkg::CODE_W_NARROW-1:0],
                       (tmq_pkg::CODE_W - tmq_pkg::CODE_W_NARROW)'(0)};
            step_q <= tmq_pkg::STEP_W'(tmq_pkg::CODE_W_NARROW - 1);
          end
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q  <= fit ? trial_sub[SW:0] : trial[SW:0];
          lo_q   <= lo_q << 1;
          quo_q  <= quo_next;
          step_q <= step_q - tmq_pkg::STEP_W'(1);
          if (step_q == '0) begin
            // flat trace: every offset is zero, code forced to zero
            code_q  <= (range_q == '0) ? '0 : quo_next;
            last_q  <= is_last;
            valid_q <= 1'b1;
            if (is_last) begin
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_READ;
            end
          end
        end

        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign result_valid_o  = valid_q;
  assign code_o          = code_q;
  assign last_code_o     = last_q;
  assign trace_minimum_o = tmq_pkg::DATA_W'(min_q);
  assign trace_range_o   = tmq_pkg::DATA_W'(range_q);

endmodule
